[src/dds_pkg.sv]
// ----------------------------------------------------------------------------
// dds_pkg
// Shared widths and constants for the drive start-up sequencer and its
// current scaling stage.
// ----------------------------------------------------------------------------
`default_nettype none

package dds_pkg;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REGEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 2'd2;
  localparam logic [CFG_DATA_W-1:0] HOLD_TICKS_RESET = 16'd1000;

  // Defaults for the top-level parameters.
  localparam int BOARDS_DEFAULT = 2;

  // Field widths.
  localparam int TICK_W = 32;
  localparam int MODE_W = 4;
  localparam int TORQUE_W = 8;
  localparam int LIMIT_W = 16;
  localparam int CMD_W = 17;
  localparam int MAG_W = CMD_W - 1;
  localparam logic [MAG_W-1:0] CMD_MAX = '1;

  // Torque magnitude times limit, before the division by 100.
  localparam int PROD_W = TORQUE_W + LIMIT_W;

  // Division by 100 as a multiply by ceil(2^30 / 100) and a shift. The
  // rounding excess is 76 / 2^30 per unit, exact for products below 2^23.
  localparam int RECIP_W = 24;
  localparam int RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
  localparam int QUOT_W = PROD_W + RECIP_W - RECIP_SHIFT;

endpackage

`default_nettype wire

[src/driverless_drive_sequencer.sv]
// ----------------------------------------------------------------------------
// driverless_drive_sequencer
// Autonomous-drive start-up sequencer with torque to current scaling.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake              Contents
//  s_*      in   s_tvalid / s_tready    one evaluation tick, board snapshot
//  m_*      out  m_tvalid / m_tready    mode, update flag, current command
//  cfg_*    in   cfg_valid / cfg_ready  register index and 16-bit value
//
// A beat is registered first in the middle stage and then in the output
// stage: the sequencer and the torque by limit multiply sit before the
// middle register, the divide by 100 and saturation after it. One beat is
// accepted per cycle while the output flows. A stall on m_tready holds
// both stages and drops s_tready. Reset puts the sequence in brake check
// and restores the register defaults; cfg_ready is always high.
`default_nettype none

module driverless_drive_sequencer #(
  parameter int BOARDS = dds_pkg::BOARDS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // now_ticks, brake_ready, supervisor_alive, mission_code, supervisor_mode,
  // button_held, battery_mode, precharge_timeout, board_alive_mask,
  // inverter_fault_mask, torque_request, estop, zero fill
  input  wire logic [((51+3*BOARDS+7)/8)*8-1:0]  s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // mode, current_update, current_command, zero fill
  output logic [23:0]                            m_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dds_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dds_pkg::*;

  localparam int OFS_BRAKE = TICK_W;
  localparam int OFS_SUP = OFS_BRAKE + 1;
  localparam int OFS_MISSION = OFS_SUP + 1;
  localparam int OFS_SMODE = OFS_MISSION + 2;
  localparam int OFS_BUTTON = OFS_SMODE + 2;
  localparam int OFS_BATT = OFS_BUTTON + 1;
  localparam int OFS_PCTO = OFS_BATT + 2;
  localparam int OFS_ALIVE = OFS_PCTO + 1;
  localparam int OFS_FAULT = OFS_ALIVE + BOARDS;
  localparam int OFS_TORQUE = OFS_FAULT + 2 * BOARDS;
  localparam int OFS_ESTOP = OFS_TORQUE + TORQUE_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_BRAKE     = 4'd0,
    MODE_MISSION   = 4'd1,
    MODE_IDLE      = 4'd2,
    MODE_PCREQ     = 4'd3,
    MODE_PRECHARGE = 4'd4,
    MODE_INVCHECK  = 4'd5,
    MODE_READY     = 4'd6,
    MODE_DRIVING   = 4'd7,
    MODE_EMERGENCY = 4'd8,
    MODE_MANUAL    = 4'd9,
    MODE_BATTCHECK = 4'd10,
    MODE_TSERROR   = 4'd11
  } mode_t;

  localparam logic [1:0] MISSION_MANUAL = 2'd1;
  localparam logic [1:0] MISSION_AUTO = 2'd2;
  localparam logic [1:0] SUP_DRIVING = 2'd1;
  localparam logic [1:0] SUP_EMERGENCY = 2'd2;
  localparam logic [1:0] BATT_READY = 2'd0;
  localparam logic [1:0] BATT_PRECHARGING = 2'd1;
  localparam logic [1:0] BATT_ACTIVE = 2'd2;

  // Configuration registers.
  logic [LIMIT_W-1:0]    max_drive_current;
  logic [LIMIT_W-1:0]    regen_limit;
  logic [CFG_DATA_W-1:0] hold_ticks;

  // Sequencer state.
  mode_t               seq_mode;
  mode_t               seq_mode_next;
  logic [TICK_W-1:0]   hold_start;
  logic                hold_running;

  // Middle stage.
  logic                mid_valid;
  logic [MODE_W-1:0]   mid_mode;
  logic                mid_update;
  logic                mid_negative;
  logic [PROD_W-1:0]   mid_product;

  // Output stage.
  logic [MODE_W-1:0]         out_mode;
  logic                      out_update;
  logic signed [CMD_W-1:0]   out_cmd;
  logic signed [CMD_W-1:0]   last_current;
  logic signed [CMD_W-1:0]   scaled_cmd;

  // Unpacked input fields.
  logic [TICK_W-1:0]      now_ticks;
  logic                   brake_ready;
  logic                   supervisor_alive;
  logic [1:0]             mission_code;
  logic [1:0]             supervisor_mode;
  logic                   button_held;
  logic [1:0]             battery_mode;
  logic                   precharge_timeout;
  logic [BOARDS-1:0]      board_alive_mask;
  logic [2*BOARDS-1:0]    inverter_fault_mask;
  logic signed [TORQUE_W-1:0] torque_request;
  logic                   estop;

  logic                   advance;
  logic                   accept;
  logic                   inverters_good;
  logic                   hold_expired;
  logic                   hold_running_next;
  logic                   start_hold;
  logic                   update;
  logic signed [TORQUE_W-1:0] torque_eff;
  logic [TORQUE_W-1:0]    torque_mag;
  logic [LIMIT_W-1:0]     limit;
  logic [PROD_W-1:0]      product;

  assign advance = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign accept = s_tvalid && advance;
  assign cfg_ready = 1'b1;

  assign now_ticks = s_tdata[TICK_W-1:0];
  assign brake_ready = s_tdata[OFS_BRAKE];
  assign supervisor_alive = s_tdata[OFS_SUP];
  assign mission_code = s_tdata[OFS_MISSION +: 2];
  assign supervisor_mode = s_tdata[OFS_SMODE +: 2];
  assign button_held = s_tdata[OFS_BUTTON];
  assign battery_mode = s_tdata[OFS_BATT +: 2];
  assign precharge_timeout = s_tdata[OFS_PCTO];
  assign board_alive_mask = s_tdata[OFS_ALIVE +: BOARDS];
  assign inverter_fault_mask = s_tdata[OFS_FAULT +: 2*BOARDS];
  assign torque_request = $signed(s_tdata[OFS_TORQUE +: TORQUE_W]);
  assign estop = s_tdata[OFS_ESTOP];

  assign inverters_good = (&board_alive_mask) && (inverter_fault_mask == '0);
  assign hold_expired = (now_ticks - hold_start) > {{(TICK_W-CFG_DATA_W){1'b0}}, hold_ticks};

  // Sequencer next state and hold timer.
  always_comb begin
    seq_mode_next = seq_mode;
    hold_running_next = hold_running;
    start_hold = 1'b0;
    update = 1'b0;
    case (seq_mode)
      MODE_BRAKE: begin
        if (brake_ready) seq_mode_next = MODE_MISSION;
      end
      MODE_MISSION: begin
        if (supervisor_alive) begin
          if (mission_code == MISSION_MANUAL) begin
            seq_mode_next = MODE_MANUAL;
          end else if (mission_code == MISSION_AUTO) begin
            seq_mode_next = MODE_IDLE;
          end
        end
      end
      MODE_IDLE: begin
        if (button_held) begin
          if (!hold_running) begin
            start_hold = 1'b1;
            hold_running_next = 1'b1;
          end else if (hold_expired) begin
            seq_mode_next = MODE_PCREQ;
          end
        end else begin
          hold_running_next = 1'b0;
        end
      end
      MODE_PCREQ: begin
        if (battery_mode == BATT_PRECHARGING || battery_mode == BATT_ACTIVE) begin
          seq_mode_next = MODE_PRECHARGE;
        end else if (battery_mode != BATT_READY) begin
          seq_mode_next = MODE_BATTCHECK;
        end
      end
      MODE_PRECHARGE: begin
        if (battery_mode == BATT_ACTIVE) begin
          seq_mode_next = MODE_INVCHECK;
        end else if (battery_mode == BATT_READY && precharge_timeout) begin
          seq_mode_next = MODE_IDLE;
        end else if (battery_mode != BATT_PRECHARGING) begin
          seq_mode_next = MODE_BATTCHECK;
        end
      end
      MODE_INVCHECK: begin
        if (inverters_good) seq_mode_next = MODE_READY;
      end
      MODE_READY: begin
        if (supervisor_mode == SUP_DRIVING) seq_mode_next = MODE_DRIVING;
      end
      MODE_DRIVING: begin
        if (!inverters_good) begin
          seq_mode_next = MODE_TSERROR;
        end else if (supervisor_mode == SUP_EMERGENCY) begin
          seq_mode_next = MODE_EMERGENCY;
        end else begin
          update = 1'b1;
        end
      end
      default: begin
        seq_mode_next = seq_mode;
      end
    endcase
    // Every entry into idle restarts the button hold.
    if (seq_mode_next == MODE_IDLE && seq_mode != MODE_IDLE) hold_running_next = 1'b0;
  end

  // Torque magnitude times the limit for its direction.
  always_comb begin
    torque_eff = (supervisor_alive && !estop) ? torque_request : '0;
    torque_mag = torque_eff[TORQUE_W-1] ? TORQUE_W'(-torque_eff) : TORQUE_W'(torque_eff);
    limit = torque_eff[TORQUE_W-1] ? regen_limit : max_drive_current;
    product = {{LIMIT_W{1'b0}}, torque_mag} * {{TORQUE_W{1'b0}}, limit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_drive_current <= '0;
      regen_limit <= '0;
      hold_ticks <= HOLD_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_DRIVE:  max_drive_current <= cfg_data;
        REG_MAX_REGEN:  regen_limit <= cfg_data;
        REG_HOLD_TICKS: hold_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_mode <= MODE_BRAKE;
      hold_start <= '0;
      hold_running <= 1'b0;
      mid_valid <= 1'b0;
    end else begin
      if (advance) mid_valid <= s_tvalid;
      if (accept) begin
        seq_mode <= seq_mode_next;
        hold_running <= hold_running_next;
        if (start_hold) hold_start <= now_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mid_mode <= seq_mode_next;
      mid_update <= update;
      mid_negative <= torque_eff[TORQUE_W-1];
      mid_product <= product;
    end
  end

  dds_scale u_scale (
    .product  (mid_product),
    .negative (mid_negative),
    .command  (scaled_cmd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      last_current <= '0;
    end else if (advance) begin
      m_tvalid <= mid_valid;
      if (mid_valid && mid_update) last_current <= scaled_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && mid_valid) begin
      out_mode <= mid_mode;
      out_update <= mid_update;
      out_cmd <= mid_update ? scaled_cmd : last_current;
    end
  end

  assign m_tdata = {2'b00, out_cmd, out_update, out_mode};

  // A recomputed command only ever leaves in driving mode.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_update |-> out_mode == MODE_DRIVING)
    else $error("current update outside driving mode");

  // The delivered command always matches the held command.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_cmd == last_current)
    else $error("output command differs from held command");

  // Exit modes hold until reset.
  assert property (@(posedge clk) disable iff (rst)
    (seq_mode == MODE_EMERGENCY || seq_mode == MODE_MANUAL ||
     seq_mode == MODE_BATTCHECK || seq_mode == MODE_TSERROR) |=> $stable(seq_mode))
    else $error("exit mode left without reset");

  // Saturation keeps the command inside the symmetric range.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_cmd != $signed({1'b1, {MAG_W{1'b0}}}))
    else $error("current command out of range");

endmodule

`default_nettype wire

[src/dds_scale.sv]
// ----------------------------------------------------------------------------
// dds_scale
// Turns the product of torque magnitude and current limit into a signed
// current command: divide by 100, saturate, apply the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_scale (
  input  wire logic [dds_pkg::PROD_W-1:0]       product,
  input  wire logic                             negative,
  output logic signed [dds_pkg::CMD_W-1:0]      command
);
  import dds_pkg::*;

  logic [PROD_W+RECIP_W-1:0] wide;
  logic [QUOT_W-1:0]         quot;
  logic [MAG_W-1:0]          mag;
  logic [CMD_W-1:0]          mag_ext;

  always_comb begin
    wide = {{RECIP_W{1'b0}}, product} * {{PROD_W{1'b0}}, RECIP_100};
    quot = wide[PROD_W+RECIP_W-1:RECIP_SHIFT];
    if (quot > QUOT_W'(CMD_MAX)) begin
      mag = CMD_MAX;
    end else begin
      mag = quot[MAG_W-1:0];
    end
    mag_ext = {1'b0, mag};
    command = negative ? -$signed(mag_ext) : $signed(mag_ext);
  end

endmodule

`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the driverless drive start-up sequencer.
// Ticks walk the start-up sequence from brake check to driving, loop through
// the button hold and precharge timeout paths, sweep the current limits while
// driving and finally leave through an exit mode. A predictor in the bench
// computes each status beat, and a checker compares every output beat with
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dds_pkg::*;

  localparam int BOARDS = BOARDS_DEFAULT;
  localparam int S_W = ((51 + 3 * BOARDS + 7) / 8) * 8;
  localparam int ALIVE_LSB = 42;
  localparam int FAULT_LSB = ALIVE_LSB + BOARDS;
  localparam int TORQUE_LSB = FAULT_LSB + 2 * BOARDS;
  localparam int ESTOP_BIT = TORQUE_LSB + TORQUE_W;
  localparam int PERCENT_FULL = 100;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic [1:0] MISSION_NONE = 2'd0;
  localparam logic [1:0] MISSION_MANUAL = 2'd1;
  localparam logic [1:0] MISSION_AUTO = 2'd2;
  localparam logic [1:0] MISSION_SPARE = 2'd3;
  localparam logic [1:0] SUP_OTHER = 2'd0;
  localparam logic [1:0] SUP_DRIVING = 2'd1;
  localparam logic [1:0] SUP_EMERGENCY = 2'd2;
  localparam logic [1:0] SUP_SPARE = 2'd3;
  localparam logic [1:0] BATT_READY = 2'd0;
  localparam logic [1:0] BATT_PRECHARGING = 2'd1;
  localparam logic [1:0] BATT_TS_ACTIVE = 2'd2;
  localparam logic [1:0] BATT_OTHER = 2'd3;

  typedef enum logic [MODE_W-1:0] {
    MD_BRAKE_CHECK, MD_MISSION, MD_IDLE, MD_PC_REQUEST, MD_PRECHARGE,
    MD_INV_CHECK, MD_READY, MD_DRIVING, MD_EMERGENCY, MD_MANUAL,
    MD_BATTERY_CHECK, MD_TS_ERROR
  } seq_mode_e;

  typedef struct {
    logic [TICK_W-1:0]     now_ticks;
    logic                  brake_ready;
    logic                  supervisor_alive;
    logic [1:0]            mission_code;
    logic [1:0]            supervisor_mode;
    logic                  button_held;
    logic [1:0]            battery_mode;
    logic                  precharge_timeout;
    logic [BOARDS-1:0]     board_alive_mask;
    logic [2*BOARDS-1:0]   inverter_fault_mask;
    logic signed [TORQUE_W-1:0] torque_request;
    logic                  estop;
  } tick_t;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic                    update;
    logic signed [CMD_W-1:0] cmd;
  } status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state and its copy of the registers.
  seq_mode_e pred_mode = MD_BRAKE_CHECK;
  logic [TICK_W-1:0] pred_hold_start = '0;
  logic pred_hold_armed = 1'b0;
  logic signed [CMD_W-1:0] pred_current = '0;
  logic [LIMIT_W-1:0] cfg_drive_lim = '0;
  logic [LIMIT_W-1:0] cfg_regen_lim = '0;
  logic [CFG_DATA_W-1:0] cfg_hold_ticks = HOLD_TICKS_RESET;

  status_t expected_status [$];
  logic [TICK_W-1:0] now_clock = '0;
  int src_idle_pct = 37;
  int sink_idle_pct = 88;
  int stall_cycles = 0;
  int mismatches = 0;
  int n_ticks = 0;
  int n_results = 0;
  int n_updates = 0;
  int n_writes = 0;
  logic [15:0] modes_seen = '0;

  always #5 clk = ~clk;

  driverless_drive_sequencer #(.BOARDS(BOARDS)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic logic [S_W-1:0] pack_tick(input tick_t t);
    logic [S_W-1:0] d;
    d = '0;
    d[31:0] = t.now_ticks;
    d[32] = t.brake_ready;
    d[33] = t.supervisor_alive;
    d[35:34] = t.mission_code;
    d[37:36] = t.supervisor_mode;
    d[38] = t.button_held;
    d[40:39] = t.battery_mode;
    d[41] = t.precharge_timeout;
    d[ALIVE_LSB +: BOARDS] = t.board_alive_mask;
    d[FAULT_LSB +: 2*BOARDS] = t.inverter_fault_mask;
    d[TORQUE_LSB +: TORQUE_W] = t.torque_request;
    d[ESTOP_BIT] = t.estop;
    return d;
  endfunction

  // Magnitude times limit over 100, truncated toward zero, then saturated.
  function automatic logic signed [CMD_W-1:0] scale_current(
      input logic signed [TORQUE_W-1:0] tq, input logic [LIMIT_W-1:0] lim);
    int tq_i;
    int unsigned mag;
    int unsigned quot;
    int cmd;
    tq_i = tq;
    mag = (tq_i < 0) ? -tq_i : tq_i;
    quot = (mag * lim) / PERCENT_FULL;
    if (quot > 32'(CMD_MAX)) quot = 32'(CMD_MAX);
    cmd = (tq_i < 0) ? -int'(quot) : int'(quot);
    return cmd[CMD_W-1:0];
  endfunction

  function automatic status_t predict_tick(input tick_t t);
    status_t r;
    seq_mode_e nxt;
    logic [TICK_W-1:0] elapsed;
    logic signed [TORQUE_W-1:0] tq;
    logic healthy;
    nxt = pred_mode;
    r.update = 1'b0;
    healthy = (t.board_alive_mask == '1) && (t.inverter_fault_mask == '0);
    elapsed = t.now_ticks - pred_hold_start;
    case (pred_mode)
      MD_BRAKE_CHECK: if (t.brake_ready) nxt = MD_MISSION;
      MD_MISSION: if (t.supervisor_alive) begin
        if (t.mission_code == MISSION_MANUAL) nxt = MD_MANUAL;
        else if (t.mission_code == MISSION_AUTO) nxt = MD_IDLE;
      end
      MD_IDLE: if (!t.button_held) begin
        pred_hold_armed = 1'b0;
      end else if (!pred_hold_armed) begin
        pred_hold_start = t.now_ticks;
        pred_hold_armed = 1'b1;
      end else if (elapsed > TICK_W'(cfg_hold_ticks)) begin
        nxt = MD_PC_REQUEST;
      end
      MD_PC_REQUEST: begin
        if (t.battery_mode == BATT_PRECHARGING || t.battery_mode == BATT_TS_ACTIVE)
          nxt = MD_PRECHARGE;
        else if (t.battery_mode != BATT_READY)
          nxt = MD_BATTERY_CHECK;
      end
      MD_PRECHARGE: begin
        if (t.battery_mode == BATT_TS_ACTIVE)
          nxt = MD_INV_CHECK;
        else if (t.battery_mode == BATT_READY && t.precharge_timeout)
          nxt = MD_IDLE;
        else if (t.battery_mode != BATT_PRECHARGING)
          nxt = MD_BATTERY_CHECK;
      end
      MD_INV_CHECK: if (healthy) nxt = MD_READY;
      MD_READY: if (t.supervisor_mode == SUP_DRIVING) nxt = MD_DRIVING;
      MD_DRIVING: if (!healthy) begin
        nxt = MD_TS_ERROR;
      end else if (t.supervisor_mode == SUP_EMERGENCY) begin
        nxt = MD_EMERGENCY;
      end else begin
        tq = (t.supervisor_alive && !t.estop) ? t.torque_request : '0;
        pred_current = scale_current(tq, (tq < 0) ? cfg_regen_lim : cfg_drive_lim);
        r.update = 1'b1;
      end
      default: ;
    endcase
    // Every entry into idle restarts the button hold from scratch.
    if (nxt == MD_IDLE && pred_mode != MD_IDLE) pred_hold_armed = 1'b0;
    pred_mode = nxt;
    r.mode = nxt;
    r.cmd = pred_current;
    return r;
  endfunction

  function automatic tick_t calm_tick();
    tick_t t;
    t.now_ticks = now_clock;
    t.brake_ready = 1'b0;
    t.supervisor_alive = 1'b1;
    t.mission_code = MISSION_NONE;
    t.supervisor_mode = SUP_OTHER;
    t.button_held = 1'b0;
    t.battery_mode = BATT_READY;
    t.precharge_timeout = 1'b0;
    t.board_alive_mask = '1;
    t.inverter_fault_mask = '0;
    t.torque_request = '0;
    t.estop = 1'b0;
    return t;
  endfunction

  // Random content, steered away from the exit modes so the sequence keeps
  // going. With climb clear, precharge always falls back to idle.
  function automatic tick_t random_tick(input bit climb);
    tick_t t;
    int tq;
    t.now_ticks = ($urandom_range(15) == 0) ? $urandom : now_clock + $urandom_range(8);
    t.brake_ready = 1'($urandom_range(1));
    t.supervisor_alive = 1'($urandom_range(1));
    t.mission_code = 2'($urandom_range(3));
    t.supervisor_mode = 2'($urandom_range(3));
    t.button_held = 1'($urandom_range(1));
    t.battery_mode = 2'($urandom_range(3));
    t.precharge_timeout = 1'($urandom_range(1));
    t.board_alive_mask = BOARDS'($urandom_range(2**BOARDS - 1));
    t.inverter_fault_mask = (2*BOARDS)'($urandom_range(2**(2*BOARDS) - 1));
    t.torque_request = TORQUE_W'($urandom_range(255));
    t.estop = 1'($urandom_range(1));
    case (pred_mode)
      MD_MISSION: begin
        if (t.supervisor_alive && t.mission_code == MISSION_MANUAL) t.mission_code = MISSION_AUTO;
      end
      MD_IDLE: t.button_held = ($urandom_range(9) < 8);
      MD_PC_REQUEST: if (t.battery_mode == BATT_OTHER) t.battery_mode = BATT_READY;
      MD_PRECHARGE: begin
        case ($urandom_range(9))
          0, 1, 2, 3: t.battery_mode = BATT_PRECHARGING;
          4, 5, 6: begin
            t.battery_mode = BATT_READY;
            t.precharge_timeout = 1'b1;
          end
          default: t.battery_mode = climb ? BATT_TS_ACTIVE : BATT_PRECHARGING;
        endcase
      end
      MD_INV_CHECK: if ($urandom_range(4) != 0) begin
        t.board_alive_mask = '1;
        t.inverter_fault_mask = '0;
      end
      MD_READY: if ($urandom_range(1)) t.supervisor_mode = SUP_DRIVING;
      MD_DRIVING: begin
        t.board_alive_mask = '1;
        t.inverter_fault_mask = '0;
        if (t.supervisor_mode == SUP_EMERGENCY)
          t.supervisor_mode = $urandom_range(1) ? SUP_DRIVING : SUP_OTHER;
        t.supervisor_alive = ($urandom_range(9) != 0);
        t.estop = ($urandom_range(9) == 0);
        if ($urandom_range(4) != 0) begin
          tq = int'($urandom_range(200)) - PERCENT_FULL;
          t.torque_request = tq[TORQUE_W-1:0];
        end
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pack_tick(t);
    do @(posedge clk); while (!s_tready);
    now_clock = t.now_ticks;
    expected_status.push_back(predict_tick(t));
    n_ticks++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAX_DRIVE: cfg_drive_lim = val;
      REG_MAX_REGEN: cfg_regen_lim = val;
      REG_HOLD_TICKS: cfg_hold_ticks = val;
      default: ;
    endcase
    n_writes++;
  endtask

  // Registers change only with nothing in flight.
  task automatic load_registers(input logic [15:0] drive, input logic [15:0] regen,
                                input logic [15:0] hold);
    drain_results();
    write_reg(REG_MAX_DRIVE, drive);
    write_reg(REG_MAX_REGEN, regen);
    write_reg(REG_HOLD_TICKS, hold);
    write_reg(REG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Directed walk on the reset register values: stalls in each early mode,
  // the hold timer starting at tick zero, a release, a hold across the tick
  // counter wrap, and both ways back to idle through a precharge timeout.
  task automatic test_reset_walk();
    tick_t t;
    t = calm_tick();
    t.now_ticks = '1; t.mission_code = MISSION_MANUAL; t.supervisor_mode = SUP_SPARE;
    t.button_held = 1'b1; t.battery_mode = BATT_OTHER; t.precharge_timeout = 1'b1;
    t.board_alive_mask = '0; t.inverter_fault_mask = '1; t.torque_request = 8'sh80;
    t.estop = 1'b1;
    send_tick(t);
    t = calm_tick(); t.brake_ready = 1'b1; send_tick(t);
    t = calm_tick(); t.supervisor_alive = 1'b0; t.mission_code = MISSION_MANUAL; send_tick(t);
    t = calm_tick(); t.mission_code = MISSION_NONE; send_tick(t);
    t = calm_tick(); t.mission_code = MISSION_SPARE; send_tick(t);
    t = calm_tick(); t.mission_code = MISSION_AUTO; send_tick(t);
    t = calm_tick(); t.now_ticks = 32'd5; send_tick(t);
    t = calm_tick(); t.now_ticks = 32'd0; t.button_held = 1'b1; send_tick(t);
    t = calm_tick(); t.now_ticks = 32'd1000; t.button_held = 1'b1; send_tick(t);
    t = calm_tick(); t.now_ticks = 32'd1001; send_tick(t);
    t = calm_tick(); t.now_ticks = 32'hFFFF_FE00; t.button_held = 1'b1; send_tick(t);
    t = calm_tick(); t.now_ticks = 32'd489; t.button_held = 1'b1; send_tick(t);
    t = calm_tick(); t.battery_mode = BATT_READY; send_tick(t);
    t = calm_tick(); t.battery_mode = BATT_PRECHARGING; send_tick(t);
    t = calm_tick(); t.battery_mode = BATT_PRECHARGING; t.precharge_timeout = 1'b1;
    send_tick(t);
    t = calm_tick(); t.battery_mode = BATT_READY; t.precharge_timeout = 1'b1; send_tick(t);
    t = calm_tick(); t.now_ticks = 32'd2000; t.button_held = 1'b1; send_tick(t);
    t = calm_tick(); t.now_ticks = 32'd3001; t.button_held = 1'b1; send_tick(t);
    t = calm_tick(); t.battery_mode = BATT_TS_ACTIVE; send_tick(t);
    t = calm_tick(); t.battery_mode = BATT_READY; t.precharge_timeout = 1'b1; send_tick(t);
  endtask

  task automatic test_hold_loop();
    load_registers(16'($urandom), 16'($urandom), 16'd0);
    repeat (100) send_tick(random_tick(1'b0));
    load_registers(16'($urandom), 16'($urandom), 16'hFFFF);
    repeat (100) send_tick(random_tick(1'b0));
  endtask

  task automatic test_reach_driving();
    int sent;
    sent = 0;
    load_registers(16'($urandom), 16'($urandom), 16'($urandom_range(30)));
    while ((sent < 150 || pred_mode != MD_DRIVING) && sent < 600) begin
      send_tick(random_tick(1'b1));
      sent++;
    end
  endtask

  task automatic test_current_scaling();
    logic signed [TORQUE_W-1:0] steps [7];
    tick_t t;
    steps = '{8'sh7F, 8'sh80, 8'sd100, -8'sd100, 8'sd1, -8'sd1, 8'sd0};
    load_registers(16'hFFFF, 16'hFFFF, cfg_hold_ticks);
    foreach (steps[i]) begin
      t = calm_tick();
      t.supervisor_mode = SUP_DRIVING;
      t.torque_request = steps[i];
      send_tick(t);
    end
    // Supervisor loss and e-stop both force a zero command.
    t = calm_tick(); t.supervisor_alive = 1'b0; t.torque_request = 8'sd50; send_tick(t);
    t = calm_tick(); t.estop = 1'b1; t.torque_request = -8'sd50; send_tick(t);
  endtask

  task automatic test_driving_limits();
    logic [15:0] drive_set [6];
    logic [15:0] regen_set [6];
    drive_set = '{16'd0, 16'd1, 16'hFFFF, 16'd100, 16'($urandom), 16'($urandom)};
    regen_set = '{16'd0, 16'hFFFF, 16'd1, 16'd100, 16'($urandom), 16'($urandom)};
    foreach (drive_set[i]) begin
      load_registers(drive_set[i], regen_set[i], 16'($urandom));
      repeat (45) send_tick(random_tick(1'b1));
    end
  endtask

  // Leave driving through an inverter fault or a supervisor emergency, then
  // confirm that the exit mode holds whatever arrives.
  task automatic test_exit_modes();
    tick_t t;
    t = calm_tick();
    t.torque_request = TORQUE_W'($urandom_range(255));
    if ($urandom_range(1)) begin
      t.inverter_fault_mask = (2*BOARDS)'(1 << $urandom_range(2*BOARDS - 1));
    end else begin
      t.supervisor_mode = SUP_EMERGENCY;
    end
    send_tick(t);
    repeat (6) send_tick(random_tick(1'b1));
  endtask

  always @(posedge clk) m_tready <= ($urandom_range(99) >= sink_idle_pct);

  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      got.mode = m_tdata[3:0];
      got.update = m_tdata[4];
      got.cmd = m_tdata[21:5];
      modes_seen[got.mode] = 1'b1;
      n_results++;
      n_updates += got.update;
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: mode %0d update %0b cmd %0d",
                   got.mode, got.update, got.cmd);
      end else begin
        want = expected_status.pop_front();
        if (got.mode !== want.mode || got.update !== want.update || got.cmd !== want.cmd) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"beat %0d: expected mode %0d update %0b cmd %0d, ",
                      "got mode %0d update %0b cmd %0d"},
                     n_results, want.mode, want.update, want.cmd,
                     got.mode, got.update, got.cmd);
        end
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("no beat moved for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_walk();
    test_hold_loop();
    src_idle_pct = 88;
    sink_idle_pct = 37;
    test_reach_driving();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_current_scaling();
    test_driving_limits();
    test_exit_modes();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d ticks, %0d status beats (%0d with a new command), %0d register writes",
             n_ticks, n_results, n_updates, n_writes);
    $display("modes reported %b, mismatches %0d, predictions left %0d",
             modes_seen, mismatches, expected_status.size());
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
